// File: rtl/bayer_grbg_demosaic_macros.svh
// Assertion macros for the Bayer demosaic RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BAYER_GRBG_DEMOSAIC_MACROS_SVH
`define BAYER_GRBG_DEMOSAIC_MACROS_SVH

`ifndef ASSERT_OFF
`define BGD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BGD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BGD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/bgd_pkg.sv
// Types, constants and the averaging function of the GRBG demosaic.
// No dependencies.
package bgd_pkg;

    localparam int PIXEL_BITS = 12;
    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int DIM_W      = 12;
    localparam int SUM_W      = PIXEL_BITS + 3;
    localparam int RECIP_W    = 16;
    localparam int IN_TDATA_W  = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 3 * PIXEL_BITS + ROW_W + COL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 2;

    // reciprocal multipliers: exact for sums below 2**17
    localparam logic [RECIP_W-1:0] RECIP3 = 16'd43691;
    localparam int                 SHIFT3 = 17;
    localparam logic [RECIP_W-1:0] RECIP5 = 16'd52429;
    localparam int                 SHIFT5 = 18;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [DIM_W-1:0] DIM_MIN      = 12'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef logic [SUM_W-1:0]      sum_t;
    typedef logic [2:0]            cnt_t;
    typedef logic [COL_W-1:0]      col_t;
    typedef logic [ROW_W-1:0]      row_t;

    // truncating average of n terms, n from 1 to 5
    function automatic pix_t avg_terms(input sum_t s, input cnt_t n);
        logic [SUM_W+RECIP_W-1:0] prod;
        logic [SUM_W+RECIP_W-1:0] q;
        prod = '0;
        q    = '0;
        case (n)
            3'd2: q = (SUM_W+RECIP_W)'(s >> 1);
            3'd3:
            begin
                prod = (SUM_W+RECIP_W)'(s) * (SUM_W+RECIP_W)'(RECIP3);
                q    = prod >> SHIFT3;
            end
            3'd4: q = (SUM_W+RECIP_W)'(s >> 2);
            3'd5:
            begin
                prod = (SUM_W+RECIP_W)'(s) * (SUM_W+RECIP_W)'(RECIP5);
                q    = prod >> SHIFT5;
            end
            default: q = (SUM_W+RECIP_W)'(s);
        endcase
        return q[PIXEL_BITS-1:0];
    endfunction

endpackage

// File: rtl/bayer_grbg_demosaic.sv
// Streaming bilinear demosaic for a GRBG Bayer mosaic, top level.
// Depends on bgd_pkg and bayer_grbg_demosaic_macros.svh.
//
//  channel  | signals                              | payload
//  ---------+--------------------------------------+--------------------------------
//  s_axis   | tvalid tready tdata[15:0]            | raw sample
//  m_axis   | tvalid tready tdata[63:0] tlast      | r g b row column, tlast = last
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data | register write, always ready
//
// One sample per cycle in steady state while the output accepts. A sample that closes a
// row after the first, or lies past column 0 on the last row, yields two to four pixels;
// the window stage then holds while the extra pixels leave through the single output
// register. Line stores are two 2048 x 12 one-read one-write memories with registered
// read. Reset clears the counters and the window; unwritten store data reach no pixel.
`include "bayer_grbg_demosaic_macros.svh"

module bayer_grbg_demosaic
    import bgd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [11:0] raw_sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [11:0] red, [23:12] green, [35:24] blue, [47:36] pixel_row, [58:48] pixel_column
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,   // last_of_run
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DIM_W-1:0]       cfg_data
);

    // configuration and counters
    logic [DIM_W-1:0] width_reg, height_reg;
    col_t             col_reg, col_next;
    row_t             row_reg, row_next;
    logic [DIM_W-1:0] w_eff, h_eff;
    col_t             w_m1;
    row_t             h_m1;

    // input stage
    logic s1_valid_reg, s1_valid_next;
    pix_t s1_sample_reg;
    col_t s1_col_reg;
    row_t s1_row_reg;
    pix_t up_q_reg, lo_q_reg;

    pix_t ram_upper [MAX_WIDTH];
    pix_t ram_lower [MAX_WIDTH];

    // window stage
    pix_t       win_reg [3][3];
    logic [3:0] pend_reg, pend_next;
    row_t       wr0_reg;
    col_t       wc0_reg;
    logic       up0_reg, lf0_reg;

    // output register
    logic out_valid_reg, out_valid_next;
    pix_t out_red_reg, out_green_reg, out_blue_reg;
    row_t out_row_reg;
    col_t out_col_reg;
    logic out_last_reg;

    logic       s_accept, cfg_accept, out_load, w_free, w_load, pend_single;
    logic [3:0] sel_bit, mask_new;
    logic       orow, ocol, up, dn, lf, rt;
    row_t       pr;
    col_t       pc;
    pix_t       nb [3][3];
    sum_t       hs, vs, ds;
    cnt_t       hn, vn, dnum;
    pix_t       red_c, green_c, blue_c;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid & cfg_ready;

    always_comb
    begin
        w_eff = width_reg;
        if (width_reg < DIM_MIN)
            w_eff = DIM_MIN;
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        h_eff = (height_reg < DIM_MIN) ? DIM_MIN : height_reg;
    end
    assign w_m1 = COL_W'(w_eff - 1'b1);
    assign h_m1 = ROW_W'(h_eff - 1'b1);

    // handshakes
    assign pend_single   = ((pend_reg & (pend_reg - 4'd1)) == 4'd0);
    assign out_load      = (pend_reg != 4'd0) & (~out_valid_reg | m_axis_tready);
    assign w_free        = (pend_reg == 4'd0) | (out_load & pend_single);
    assign w_load        = s1_valid_reg & w_free;
    assign s_axis_tready = ~s1_valid_reg | w_load;
    assign s_accept      = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_accept && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT))
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (s_accept)
        begin
            if (col_reg == w_m1)
            begin
                col_next = '0;
                row_next = (row_reg == h_m1) ? '0 : row_reg + 1'b1;
            end
            else
                col_next = col_reg + 1'b1;
        end
    end

    assign s1_valid_next = s_accept | (s1_valid_reg & ~w_load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_accept && cfg_index == REG_FRAME_WIDTH)
                width_reg <= cfg_data;
            if (cfg_accept && cfg_index == REG_FRAME_HEIGHT)
                height_reg <= cfg_data;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_sample_reg <= s_axis_tdata[PIXEL_BITS-1:0];
            s1_col_reg    <= col_reg;
            s1_row_reg    <= row_reg;
        end
    end

    // line stores: read at acceptance, write back when the sample enters the window
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            up_q_reg <= ram_upper[col_reg];
            lo_q_reg <= ram_lower[col_reg];
        end
        if (w_load)
        begin
            ram_upper[s1_col_reg] <= lo_q_reg;
            ram_lower[s1_col_reg] <= s1_sample_reg;
        end
    end

    // pixels this sample releases, in emission order
    always_comb
    begin
        mask_new[0] = (s1_row_reg != '0) & (s1_col_reg != '0);
        mask_new[1] = (s1_row_reg != '0) & (s1_col_reg == w_m1);
        mask_new[2] = (s1_row_reg == h_m1) & (s1_col_reg != '0);
        mask_new[3] = (s1_row_reg == h_m1) & (s1_col_reg == w_m1);
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (w_load)
            pend_next = mask_new;
        else if (out_load)
            pend_next = pend_reg & ~sel_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (w_load)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= up_q_reg;
                win_reg[1][2] <= lo_q_reg;
                win_reg[2][2] <= s1_sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_load)
        begin
            wr0_reg <= s1_row_reg - 1'b1;
            wc0_reg <= s1_col_reg - 1'b1;
            up0_reg <= (s1_row_reg > ROW_W'(1));
            lf0_reg <= (s1_col_reg > COL_W'(1));
        end
    end

    // pick the next pending pixel and its neighborhood
    assign sel_bit = pend_reg & (~pend_reg + 4'd1);
    assign orow    = sel_bit[2] | sel_bit[3];
    assign ocol    = sel_bit[1] | sel_bit[3];
    assign pr      = orow ? h_m1 : wr0_reg;
    assign pc      = ocol ? w_m1 : wc0_reg;
    assign up      = orow | up0_reg;
    assign dn      = ~orow;
    assign lf      = ocol | lf0_reg;
    assign rt      = ~ocol;

    always_comb
    begin
        int rr;
        int cc;
        for (int dr = 0; dr < 3; dr++)
            for (int dc = 0; dc < 3; dc++)
            begin
                rr = dr + int'(orow);
                cc = dc + int'(ocol);
                if (rr <= 2 && cc <= 2)
                    nb[dr][dc] = win_reg[2'(rr)][2'(cc)];
                else
                    nb[dr][dc] = '0;
            end
    end

    always_comb
    begin
        hs   = (lf ? SUM_W'(nb[1][0]) : '0) + (rt ? SUM_W'(nb[1][2]) : '0);
        hn   = cnt_t'(lf) + cnt_t'(rt);
        vs   = (up ? SUM_W'(nb[0][1]) : '0) + (dn ? SUM_W'(nb[2][1]) : '0);
        vn   = cnt_t'(up) + cnt_t'(dn);
        ds   = ((up & lf) ? SUM_W'(nb[0][0]) : '0) + ((up & rt) ? SUM_W'(nb[0][2]) : '0)
             + ((dn & lf) ? SUM_W'(nb[2][0]) : '0) + ((dn & rt) ? SUM_W'(nb[2][2]) : '0);
        dnum = cnt_t'(up & lf) + cnt_t'(up & rt) + cnt_t'(dn & lf) + cnt_t'(dn & rt);
        if (pr[0] == pc[0])
        begin
            // green site
            green_c = avg_terms(SUM_W'(nb[1][1]) + ds, dnum + 3'd1);
            if (!pr[0])
            begin
                red_c  = avg_terms(hs, hn);
                blue_c = avg_terms(vs, vn);
            end
            else
            begin
                red_c  = avg_terms(vs, vn);
                blue_c = avg_terms(hs, hn);
            end
        end
        else if (!pr[0])
        begin
            red_c   = nb[1][1];
            green_c = avg_terms(hs + vs, hn + vn);
            blue_c  = avg_terms(ds, dnum);
        end
        else
        begin
            blue_c  = nb[1][1];
            green_c = avg_terms(hs + vs, hn + vn);
            red_c   = avg_terms(ds, dnum);
        end
    end

    assign out_valid_next = out_load | (out_valid_reg & ~m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_red_reg   <= red_c;
            out_green_reg <= green_c;
            out_blue_reg  <= blue_c;
            out_row_reg   <= pr;
            out_col_reg   <= pc;
            out_last_reg  <= ((pend_reg & ~sel_bit) == 4'd0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_col_reg, out_row_reg,
                            out_blue_reg, out_green_reg, out_red_reg};

    `BGD_ASSERT_IMPL(a_col_range, clk, rst_n, m_axis_tvalid, out_col_reg <= w_m1)
    `BGD_ASSERT_IMPL(a_row_range, clk, rst_n, m_axis_tvalid, out_row_reg <= h_m1)
    `BGD_ASSERT_IMPL(a_no_rw_clash, clk, rst_n, w_load && s_accept, col_reg != s1_col_reg)
    `BGD_ASSERT_NEXT(a_pend_drain, clk, rst_n, out_load && !w_load, $countones(pend_reg) + 1 == $countones($past(pend_reg)))

endmodule

// File: verif/bayer_grbg_demosaic_tb.sv
// Self-checking testbench for bayer_grbg_demosaic: streams raw GRBG frames in,
// predicts every demosaiced pixel and compares it field by field.
// Depends on bgd_pkg and the RTL of bayer_grbg_demosaic.
`timescale 1ns / 100ps

module bayer_grbg_demosaic_tb
    import bgd_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 12;
    localparam int unsigned RANDOM_ITEMS = 280;

    typedef struct packed {
        pix_t red;
        pix_t green;
        pix_t blue;
        row_t row;
        col_t column;
        logic last;
    } pixel_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DIM_W-1:0]       cfg_data;

    bayer_grbg_demosaic u_top (.*);

    // predictor state
    pix_t        upper_line [MAX_WIDTH];
    pix_t        lower_line [MAX_WIDTH];
    pix_t        win [3][3];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    pixel_t      pending_pixels [$];

    int unsigned samples_in;
    int unsigned pixels_out;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned frames_done;
    bit          idling_on;
    int          hold_req;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int unsigned width_eff();
        int unsigned w;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned height_eff();
        return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function automatic int unsigned mean_of(int unsigned s, int unsigned n);
        return (n == 0) ? s : s / n;
    endfunction

    function automatic int unsigned win_val(int rr, int cc);
        if (rr < 0 || rr > 2 || cc < 0 || cc > 2) return 0;
        return win[rr][cc];
    endfunction

    function automatic pixel_t interpolate(int orow, int ocol, int unsigned r,
                                           int unsigned c);
        int unsigned w, h, ctr, hs, vs, ds, hn, vn, dn, rv, gv, bv;
        int cr, cc;
        bit up, down, left, right;
        pixel_t p;
        w = width_eff();
        h = height_eff();
        cr = 1 + orow;
        cc = 1 + ocol;
        up = r > 0;
        down = r + 1 < h;
        left = c > 0;
        right = c + 1 < w;
        ctr = win_val(cr, cc);
        hs = 0; vs = 0; ds = 0; hn = 0; vn = 0; dn = 0;
        if (left) begin hs += win_val(cr, cc - 1); hn++; end
        if (right) begin hs += win_val(cr, cc + 1); hn++; end
        if (up) begin vs += win_val(cr - 1, cc); vn++; end
        if (down) begin vs += win_val(cr + 1, cc); vn++; end
        if (up && left) begin ds += win_val(cr - 1, cc - 1); dn++; end
        if (up && right) begin ds += win_val(cr - 1, cc + 1); dn++; end
        if (down && left) begin ds += win_val(cr + 1, cc - 1); dn++; end
        if (down && right) begin ds += win_val(cr + 1, cc + 1); dn++; end
        if (((r ^ c) & 1) == 0)
        begin
            gv = mean_of(ctr + ds, 1 + dn);
            rv = (r & 1) ? mean_of(vs, vn) : mean_of(hs, hn);
            bv = (r & 1) ? mean_of(hs, hn) : mean_of(vs, vn);
        end
        else if ((r & 1) == 0)
        begin
            rv = ctr;
            gv = mean_of(hs + vs, hn + vn);
            bv = mean_of(ds, dn);
        end
        else
        begin
            bv = ctr;
            gv = mean_of(hs + vs, hn + vn);
            rv = mean_of(ds, dn);
        end
        p.red = pix_t'(rv);
        p.green = pix_t'(gv);
        p.blue = pix_t'(bv);
        p.row = row_t'(r);
        p.column = col_t'(c);
        p.last = 1'b0;
        return p;
    endfunction

    // advance the window and queue the pixels this sample completes
    task automatic demosaic_sample(input pix_t x);
        int unsigned w, h, i, j, n;
        pixel_t made [$];
        w = width_eff();
        h = height_eff();
        i = row_pos;
        j = col_pos;
        for (int rr = 0; rr < 3; rr++)
        begin
            win[rr][0] = win[rr][1];
            win[rr][1] = win[rr][2];
        end
        win[0][2] = upper_line[j];
        win[1][2] = lower_line[j];
        win[2][2] = x;
        upper_line[j] = lower_line[j];
        lower_line[j] = x;
        if (i >= 1 && j >= 1) made.push_back(interpolate(0, 0, i - 1, j - 1));
        if (i >= 1 && j == w - 1) made.push_back(interpolate(0, 1, i - 1, w - 1));
        if (i == h - 1 && j >= 1) made.push_back(interpolate(1, 0, h - 1, j - 1));
        if (i == h - 1 && j == w - 1) made.push_back(interpolate(1, 1, h - 1, w - 1));
        n = made.size();
        if (n > 0) made[n - 1].last = 1'b1;
        foreach (made[k]) pending_pixels.push_back(made[k]);
        if (j + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (i + 1 >= h) ? 0 : i + 1;
        end
        else
            col_pos = j + 1;
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        $display("ERROR pixel %0d: %s got %0d, expected %0d", pixels_out, what, got, want);
    endtask

    function automatic int unsigned gap_cycles();
        int unsigned r;
        if (!idling_on) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a falling edge; returns at a falling edge with tvalid held high
    task automatic send_sample(input pix_t x);
        int unsigned gap;
        gap = gap_cycles();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = IN_TDATA_W'(x);
        do @(posedge clk); while (!s_axis_tready);
        samples_in++;
        demosaic_sample(x);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending_pixels.size() > 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT)
        begin
            if (idx == REG_FRAME_WIDTH) width_reg = val;
            else height_reg = val;
            col_pos = 0;
            row_pos = 0;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) send_sample(pix_t'($urandom));
    endtask

    // reset sizes 640 x 480: a stretch of the first row gives no pixels
    task automatic test_reset_size();
        send_random(20);
    endtask

    task automatic test_directed();
        idling_on = 1'b0;
        set_frame(12'd3, 12'd3);
        repeat (9) send_sample(12'hFFF);
        set_frame(12'd4, 12'd4);
        for (int k = 0; k < 16; k++)
            send_sample(((k + k / 4) & 1) ? 12'hFFF : 12'h000);
        frames_done += 2;
        idling_on = 1'b1;
    endtask

    // out-of-range sizes clamp; also drives every bit of both registers
    task automatic test_clamping();
        set_frame(12'd0, 12'd1);
        send_random(9);
        set_frame(12'd2, 12'd0);
        send_random(9);
        set_frame(12'hFFF, 12'hFFF);
        send_random(40);
        frames_done += 2;
    endtask

    // writes to unused indexes must not restart the frame
    task automatic test_unused_index();
        set_frame(12'd5, 12'd4);
        send_random(7);
        write_reg(REG_SPARE_2, 12'hFFF);
        write_reg(REG_SPARE_3, 12'h000);
        send_random(13);
        frames_done++;
    endtask

    // receiver holds off so the block backs up, then the sender waits it out
    task automatic test_back_pressure();
        set_frame(12'd6, 12'd5);
        hold_req = 300;
        send_random(30);
        drain();
        frames_done++;
    endtask

    task automatic test_random_frames();
        int unsigned w, h, sent, n;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 24) : $urandom_range(3, 9);
            h = $urandom_range(3, 8);
            idling_on = $urandom_range(0, 3) != 0;
            set_frame(DIM_W'(w), DIM_W'(h));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h) : w * h;
            // sometimes run a second frame back to back
            if (n == w * h && $urandom_range(0, 3) == 0) n = 2 * n;
            if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
            for (int k = 0; k < n; k++)
                case ($urandom_range(0, 9))
                    0: send_sample(12'h000);
                    1: send_sample(12'hFFF);
                    default: send_sample(pix_t'($urandom));
                endcase
            sent += n;
            frames_done++;
        end
        idling_on = 1'b1;
    endtask

    // result checker
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("unexpected pixel count", 1, 0);
            else
            begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata[11:0] !== want.red)
                    report_mismatch("red", m_axis_tdata[11:0], want.red);
                if (m_axis_tdata[23:12] !== want.green)
                    report_mismatch("green", m_axis_tdata[23:12], want.green);
                if (m_axis_tdata[35:24] !== want.blue)
                    report_mismatch("blue", m_axis_tdata[35:24], want.blue);
                if (m_axis_tdata[47:36] !== want.row)
                    report_mismatch("pixel_row", m_axis_tdata[47:36], want.row);
                if (m_axis_tdata[58:48] !== want.column)
                    report_mismatch("pixel_column", m_axis_tdata[58:48], want.column);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_of_run", m_axis_tlast, want.last);
            end
            pixels_out++;
        end
    end

    // output stalls: random short and long, plus requested hold-offs
    always @(negedge clk)
    begin
        int hold_left;
        int stall_left;
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready = 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                      : $urandom_range(0, 2);
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = 1'b1;
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        hold_req = 0;
        idling_on = 1'b1;
        samples_in = 0;
        pixels_out = 0;
        mismatches = 0;
        quiet_cycles = 0;
        frames_done = 0;
        foreach (upper_line[k]) upper_line[k] = '0;
        foreach (lower_line[k]) lower_line[k] = '0;
        foreach (win[a, b]) win[a][b] = '0;
        col_pos = 0;
        row_pos = 0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_size();
        test_directed();
        test_clamping();
        test_unused_index();
        test_back_pressure();
        test_random_frames();
        drain();

        $display("Covered %0d samples and %0d pixels over %0d frames,", samples_in,
                 pixels_out, frames_done);
        $display("including clamped sizes, spare register writes and output hold-off.");
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/bgd_pkg.sv
rtl/bayer_grbg_demosaic.sv
verif/bayer_grbg_demosaic_tb.sv
